/* rtl/bqf_pkg.sv */
// Shared types, widths and microcode codes for the biquad filter.
package bqf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int STATE_W    = 56;
  localparam int STATE_FRAC = 46;

  // Product is shifted down to the state grid
  localparam int PROD_W  = SAMPLE_W + COEF_W;
  localparam int PROD_SH = (SAMPLE_W - 1) + (COEF_W - 2) - STATE_FRAC;
  localparam int PQ_W    = PROD_W - PROD_SH;

  // Accumulator, one more bit for a subtract, and output rounding
  localparam int ACC_W  = STATE_W + 1;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RND_SH = STATE_FRAC - (SAMPLE_W - 1);
  localparam int RS_W   = SUM_W - RND_SH;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1) <<< (COEF_W - 2);

  // Microprogram steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_B1   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_OUT  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_A1   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_A2   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_Z2   = STEP_W'(5);

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_IN_VALID = 2'd1,
    COND_OUT_FREE = 2'd2
  } cond_e;

  typedef enum logic [1:0] {
    SMP_IN = 2'd0,
    SMP_X  = 2'd1,
    SMP_Y  = 2'd2
  } smp_sel_e;

  typedef enum logic [2:0] {
    CF_B0 = 3'd0,
    CF_B1 = 3'd1,
    CF_B2 = 3'd2,
    CF_A1 = 3'd3,
    CF_A2 = 3'd4
  } coef_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_P_Z1 = 2'd1,
    ACC_P_Z2 = 2'd2
  } acc_op_e;

  typedef enum logic {
    Z1_HOLD    = 1'b0,
    Z1_ACC_SUB = 1'b1
  } z1_op_e;

  typedef enum logic [1:0] {
    Z2_HOLD   = 2'd0,
    Z2_LOAD_P = 2'd1,
    Z2_SUB_P  = 2'd2
  } z2_op_e;

  // One microcode word
  typedef struct packed {
    cond_e             cond;
    logic              jump;
    logic [STEP_W-1:0] target;
    smp_sel_e          smp_sel;
    coef_sel_e         coef_sel;
    acc_op_e           acc_op;
    z1_op_e            z1_op;
    z2_op_e            z2_op;
    logic              x_load;
    logic              y_load;
  } ucode_t;

  // Datapath controls for the current step
  typedef struct packed {
    logic      en;
    smp_sel_e  smp_sel;
    coef_sel_e coef_sel;
    acc_op_e   acc_op;
    z1_op_e    z1_op;
    z2_op_e    z2_op;
    logic      x_load;
    logic      y_load;
  } ctl_t;

  // Handshake status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

endpackage

/* rtl/biquad_tdf2_filter.sv */
// Top level of the transposed direct form II biquad section.
//
// Usage:
//   Samples enter on the slave stream (signed Q1.23 in s_axis_tdata[23:0]),
//   one accepted per transaction. Each produces one result on the master
//   stream: the rounded, saturated sample in m_axis_tdata[23:0] and the
//   clip flag in m_axis_tuser[0].
//   Coefficients b0, b1, b2, a1, a2 (signed Q2.30) are written through the
//   cfg port at indexes 0 to 4 while the filter is idle; other indexes are
//   ignored.
//   m_axis_tvalid rises once the sample has passed the product, accumulator
//   and output registers. The six-step microprogram runs all five products
//   through one shared 24x32 multiplier.
//   A new sample is taken only in the first step, while a finished result
//   may still wait in the output register.
//   Reset clears both delay states, sets b0 to 1.0 and the others to zero,
//   and empties the output register.
//   Receiver stall: the result register holds its value; the program waits
//   at its output step only if the previous result has not been taken yet.
module biquad_tdf2_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write port
  input  logic                                   cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [bqf_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [bqf_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // [23:0] sample_in
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [bqf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [23:0] sample_out
  output logic [bqf_pkg::OUT_TUSER_W-1:0]        m_axis_tuser   // [0] clipped
);
  import bqf_pkg::*;

  ctl_t                       ctl;
  stat_t                      stat;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clip;

  bqf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .in_ready_o (s_axis_tready)
  );

  bqf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_sample_i  (s_axis_tdata[SAMPLE_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_clip_o   (out_clip)
  );

  // Pack the output payload
  assign m_axis_tdata = OUT_TDATA_W'(unsigned'(out_sample));
  assign m_axis_tuser = OUT_TUSER_W'(out_clip);

endmodule

/* rtl/bqf_sequencer.sv */
// Microcode ROM, step counter and branch logic of the biquad filter.
module bqf_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bqf_pkg::stat_t stat_i,
  output bqf_pkg::ctl_t  ctl_o,
  output logic           in_ready_o
);
  import bqf_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              go;

  // Read the control word of the current step
  always_comb begin
    uc = '{cond: COND_ALWAYS, jump: 1'b1, target: STEP_IDLE, smp_sel: SMP_X,
           coef_sel: CF_B0, acc_op: ACC_HOLD, z1_op: Z1_HOLD, z2_op: Z2_HOLD,
           x_load: 1'b0, y_load: 1'b0};
    case (step_q)
      STEP_IDLE: begin
        // wait for a sample, multiply it by b0 straight from the port
        uc.cond     = COND_IN_VALID;
        uc.jump     = 1'b0;
        uc.smp_sel  = SMP_IN;
        uc.coef_sel = CF_B0;
        uc.x_load   = 1'b1;
      end
      STEP_B1: begin
        uc.jump     = 1'b0;
        uc.acc_op   = ACC_P_Z1;
        uc.smp_sel  = SMP_X;
        uc.coef_sel = CF_B1;
      end
      STEP_OUT: begin
        // needs a free output slot to post the result
        uc.cond     = COND_OUT_FREE;
        uc.jump     = 1'b0;
        uc.y_load   = 1'b1;
        uc.acc_op   = ACC_P_Z2;
        uc.smp_sel  = SMP_X;
        uc.coef_sel = CF_B2;
      end
      STEP_A1: begin
        uc.jump     = 1'b0;
        uc.z2_op    = Z2_LOAD_P;
        uc.smp_sel  = SMP_Y;
        uc.coef_sel = CF_A1;
      end
      STEP_A2: begin
        uc.jump     = 1'b0;
        uc.z1_op    = Z1_ACC_SUB;
        uc.smp_sel  = SMP_Y;
        uc.coef_sel = CF_A2;
      end
      STEP_Z2: begin
        uc.jump   = 1'b1;
        uc.target = STEP_IDLE;
        uc.z2_op  = Z2_SUB_P;
      end
      default: begin
        uc.jump   = 1'b1;
        uc.target = STEP_IDLE;
      end
    endcase
  end

  // Evaluate the step condition
  always_comb begin
    case (uc.cond)
      COND_ALWAYS:   go = 1'b1;
      COND_IN_VALID: go = stat_i.in_valid;
      COND_OUT_FREE: go = stat_i.out_free;
      default:       go = 1'b0;
    endcase
  end

  // Advance, branch or hold the step counter
  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = uc.jump ? uc.target : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o = (uc.cond == COND_IN_VALID);

  assign ctl_o = '{en: go, smp_sel: uc.smp_sel, coef_sel: uc.coef_sel,
                   acc_op: uc.acc_op, z1_op: uc.z1_op, z2_op: uc.z2_op,
                   x_load: uc.x_load, y_load: uc.y_load};

endmodule

/* rtl/bqf_datapath.sv */
// Coefficient registers, shared multiplier, accumulator, delay states and output stage.
module bqf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqf_pkg::ctl_t                       ctl_i,
  output bqf_pkg::stat_t                      stat_o,
  input  logic                                cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bqf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bqf_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                out_clip_o
);
  import bqf_pkg::*;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (RND_SH - 1);
  localparam logic signed [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [SAMPLE_W-1:0] x_q, y_q;
  logic                       clip_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PQ_W-1:0]     pq;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [STATE_W-1:0]  z1_q, z1_d, z2_q, z2_d;
  logic signed [SUM_W-1:0]    z1_sum, z2_sum, rnd;
  logic signed [RS_W-1:0]     rs;
  logic signed [SAMPLE_W-1:0] y_d;
  logic                       clip_d;

  // Clamp a wide sum to the state range
  function automatic logic signed [STATE_W-1:0] sat_state(logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] top;
    top = v[SUM_W-1:STATE_W-1];
    if ((&top) || !(|top)) begin
      return v[STATE_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // Write coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  b0_q <= cfg_data_i[COEF_W-1:0];
        REG_B1:  b1_q <= cfg_data_i[COEF_W-1:0];
        REG_B2:  b2_q <= cfg_data_i[COEF_W-1:0];
        REG_A1:  a1_q <= cfg_data_i[COEF_W-1:0];
        REG_A2:  a2_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctl_i.smp_sel)
      SMP_IN:  mul_a = in_sample_i;
      SMP_X:   mul_a = x_q;
      SMP_Y:   mul_a = y_q;
      default: mul_a = x_q;
    endcase
    case (ctl_i.coef_sel)
      CF_B0:   mul_b = b0_q;
      CF_B1:   mul_b = b1_q;
      CF_B2:   mul_b = b2_q;
      CF_A1:   mul_b = a1_q;
      CF_A2:   mul_b = a2_q;
      default: mul_b = b0_q;
    endcase
  end

  assign prod_d = mul_a * mul_b;
  // floor shift of the exact product onto the state grid
  assign pq     = prod_q[PROD_W-1:PROD_SH];

  // Accumulate and update delay states
  assign z1_sum = SUM_W'(acc_q) - SUM_W'(pq);
  assign z2_sum = SUM_W'(z2_q) - SUM_W'(pq);

  always_comb begin
    case (ctl_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_P_Z1: acc_d = ACC_W'(pq) + ACC_W'(z1_q);
      ACC_P_Z2: acc_d = ACC_W'(pq) + ACC_W'(z2_q);
      default:  acc_d = acc_q;
    endcase
    case (ctl_i.z1_op)
      Z1_HOLD:    z1_d = z1_q;
      Z1_ACC_SUB: z1_d = sat_state(z1_sum);
      default:    z1_d = z1_q;
    endcase
    case (ctl_i.z2_op)
      Z2_HOLD:   z2_d = z2_q;
      Z2_LOAD_P: z2_d = STATE_W'(pq);
      Z2_SUB_P:  z2_d = sat_state(z2_sum);
      default:   z2_d = z2_q;
    endcase
  end

  // Round half up to the sample grid, then saturate
  assign rnd = SUM_W'(acc_q) + RND_HALF;
  assign rs  = rnd[SUM_W-1:RND_SH];

  always_comb begin
    clip_d = !((&rs[RS_W-1:SAMPLE_W-1]) || !(|rs[RS_W-1:SAMPLE_W-1]));
    if (clip_d) begin
      y_d = rs[RS_W-1] ? Y_MIN : Y_MAX;
    end else begin
      y_d = rs[SAMPLE_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      if (ctl_i.x_load) begin
        x_q <= in_sample_i;
      end
      if (ctl_i.y_load) begin
        y_q    <= y_d;
        clip_q <= clip_d;
      end
    end
  end

  // Delay states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
    end else if (ctl_i.en) begin
      z1_q <= z1_d;
      z2_q <= z2_d;
    end
  end

  // Output slot: hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.en && ctl_i.y_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o       = '{in_valid: in_valid_i, out_free: !out_valid_q || out_ready_i};
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = y_q;
  assign out_clip_o   = clip_q;

endmodule

/* rtl/bqf_checker.sv */
// Port-level assertions for the biquad filter, bound to the top level.
module bqf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bqf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [bqf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import bqf_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // No new sample is taken during the five steps after an accepted one
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready
              ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while a sample was in progress");

  // A clipped result carries a full-scale value
  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[SAMPLE_W-1:0] == {1'b0, {(SAMPLE_W-1){1'b1}}}) ||
      (m_axis_tdata[SAMPLE_W-1:0] == {1'b1, {(SAMPLE_W-1){1'b0}}}))
    else $error("clip flag without a saturated sample");

  // A fresh result rises only after an accepted input has passed the product, accumulator and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc, 3))
    else $error("result appeared without a matching input");

endmodule

bind biquad_tdf2_filter bqf_checker u_bqf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/biquad_tdf2_filter_test.sv */
// Self-checking stream testbench for the transposed direct form II biquad section.
`timescale 1ns / 100ps

module biquad_tdf2_filter_test;
  import bqf_pkg::*;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_PHASE    = 3;
  localparam int NUM_COEFS     = 5;

  // Indexes past the last coefficient; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_VOID_LO  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] IDX_VOID_MID = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] IDX_VOID_HI  = CFG_IDX_W'(7);

  localparam logic [CFG_IDX_W-1:0] COEF_REGS [NUM_COEFS] =
    '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

  localparam logic [COEF_W-1:0] COEF_TOP    = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_BOTTOM = 32'h8000_0000;

  typedef enum logic [1:0] {
    ROW_CFG = 2'd0,
    ROW_SMP = 2'd1,
    ROW_CHK = 2'd2
  } row_kind_e;

  typedef enum logic [2:0] {
    MIX_GENTLE = 3'd0,
    MIX_WIDE   = 3'd1,
    MIX_PASS   = 3'd2,
    MIX_EDGES  = 3'd3,
    MIX_TOP    = 3'd4,
    MIX_BOTTOM = 3'd5
  } coef_mix_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [SAMPLE_W-1:0]   exp_smp;
    logic                  exp_clip;
  } stim_row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                clip;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } reg_write_t;

  // Directed rows: sample rows carry the sample in the low bits of val
  localparam int NUM_DIRECTED = 33;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // pass-through after reset
    '{ROW_CHK, REG_B0, 32'h0000_0000, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h007F_FFFF, 24'h7FFFFF, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0080_0000, 24'h800000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0000_0001, 24'h000001, 1'b0},
    '{ROW_CHK, REG_B0, 32'h00FF_FFFF, 24'hFFFFFF, 1'b0},
    // largest positive gain saturates full-scale inputs
    '{ROW_CFG, REG_B0, 32'h7FFF_FFFF, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h007F_FFFF, 24'h7FFFFF, 1'b1},
    '{ROW_CHK, REG_B0, 32'h0080_0000, 24'h800000, 1'b1},
    // largest negative gain flips and saturates
    '{ROW_CFG, REG_B0, 32'h8000_0000, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0080_0000, 24'h7FFFFF, 1'b1},
    '{ROW_CHK, REG_B0, 32'h007F_FFFF, 24'h800000, 1'b1},
    '{ROW_CHK, REG_B0, 32'h0000_0000, 24'h000000, 1'b0},
    // unused indexes must leave every coefficient alone
    '{ROW_CFG, IDX_VOID_LO,  32'h4000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, IDX_VOID_MID, 32'h4000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, IDX_VOID_HI,  32'h4000_0000, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0000_0001, 24'hFFFFFE, 1'b0},
    '{ROW_SMP, REG_B0, 32'h007F_FFFF, 24'h000000, 1'b0},
    // half gain: exact halves round upward
    '{ROW_CFG, REG_B0, 32'h2000_0000, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0000_0001, 24'h000001, 1'b0},
    '{ROW_CHK, REG_B0, 32'h00FF_FFFF, 24'h000000, 1'b0},
    '{ROW_CHK, REG_B0, 32'h0000_0003, 24'h000002, 1'b0},
    '{ROW_CHK, REG_B0, 32'h00FF_FFFD, 24'hFFFFFF, 1'b0},
    // extreme feedback: saturated output drives the delay line
    '{ROW_CFG, REG_B0, 32'h1000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, REG_B1, 32'h2000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, REG_B2, 32'h1000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, REG_A1, 32'h8000_0000, 24'h000000, 1'b0},
    '{ROW_CFG, REG_A2, 32'h7FFF_FFFF, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h007F_FFFF, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h0080_0000, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h0012_3456, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h0000_0000, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h00FF_FFFF, 24'h000000, 1'b0},
    '{ROW_SMP, REG_B0, 32'h0040_0000, 24'h000000, 1'b0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  // Filter mirror: coefficients and both delay elements
  logic signed [COEF_W-1:0]  gain_b0, gain_b1, gain_b2, gain_a1, gain_a2;
  logic signed [STATE_W-1:0] z1_q, z2_q;

  result_t    filtered_q [$];
  reg_write_t pending_writes [$];
  int         mismatch_cnt = 0;
  bit         no_idle      = 1'b0;
  bit         hold_req     = 1'b0;

  always #5 clk_i = ~clk_i;

  biquad_tdf2_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [23:0] sample_in
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [23:0] sample_out
    .m_axis_tuser  (m_axis_tuser)    // [0] clipped
  );

  // Exact product brought to the state grid, rounded toward minus infinity
  function automatic longint prod_to_state(longint s, longint c);
    return (s * c) >>> PROD_SH;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void set_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_B0: gain_b0 = val;
      REG_B1: gain_b1 = val;
      REG_B2: gain_b2 = val;
      REG_A1: gain_a1 = val;
      REG_A2: gain_a2 = val;
      default: ;
    endcase
  endfunction

  // Run one sample through the mirror and advance its delay line
  function automatic result_t filter_step(logic [SAMPLE_W-1:0] x_raw);
    longint  x, acc, y, n1, n2;
    result_t r;
    x   = longint'($signed(x_raw));
    acc = prod_to_state(x, longint'(gain_b0)) + longint'(z1_q);
    acc = (acc + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
    y   = clamp(acc, SAMPLE_W);
    n1  = prod_to_state(x, longint'(gain_b1)) - prod_to_state(y, longint'(gain_a1))
          + longint'(z2_q);
    n2  = prod_to_state(x, longint'(gain_b2)) - prod_to_state(y, longint'(gain_a2));
    z1_q = STATE_W'(clamp(n1, STATE_W));
    z2_q = STATE_W'(clamp(n2, STATE_W));
    r.smp  = y[SAMPLE_W-1:0];
    r.clip = (y != acc);
    return r;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int send_gap();
    if (no_idle || $urandom_range(0, 9) < 4) return 0;
    return idle_len();
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        2: return 24'h000000;
        default: return 24'hFFFFFF;
      endcase
    end
    if (r < 3) return SAMPLE_W'($urandom_range(0, 512) - 256);
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(coef_mix_e mix);
    case (mix)
      MIX_GENTLE: return COEF_W'($urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
      MIX_WIDE:   return COEF_W'($urandom());
      MIX_TOP:    return COEF_TOP;
      MIX_BOTTOM: return COEF_BOTTOM;
      default: begin
        case ($urandom_range(0, 3))
          0: return COEF_TOP;
          1: return COEF_BOTTOM;
          2: return '0;
          default: return COEF_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // Drop valid and wait until the filter has finished all outstanding work
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the pending coefficient list while the filter is idle
  task automatic flush_writes();
    wait_drained();
    foreach (pending_writes[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= pending_writes[i].idx;
      cfg_data_i <= pending_writes[i].val;
      @(posedge clk_i);
      set_coef(pending_writes[i].idx, pending_writes[i].val);
    end
    cfg_we_i <= 1'b0;
    pending_writes.delete();
  endtask

  // Offer one sample, record its expected result once the transaction completes
  task automatic send_sample(logic [SAMPLE_W-1:0] x, bit fixed, result_t fixed_res);
    result_t r;
    int      gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    r = filter_step(x);
    filtered_q.push_back(fixed ? fixed_res : r);
    gap = send_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stimulus: reset, directed table, then randomized phases
  initial begin
    int        random_sent;
    int        phase;
    int        n_items;
    coef_mix_e mix;
    random_sent = 0;
    phase       = 0;
    gain_b0 = B0_RESET;
    gain_b1 = '0;
    gain_b2 = '0;
    gain_a1 = '0;
    gain_a2 = '0;
    z1_q    = '0;
    z2_q    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        pending_writes.push_back('{DIRECTED[i].idx, DIRECTED[i].val});
        if (i + 1 == NUM_DIRECTED || DIRECTED[i + 1].kind != ROW_CFG) flush_writes();
      end else begin
        send_sample(DIRECTED[i].val[SAMPLE_W-1:0], DIRECTED[i].kind == ROW_CHK,
                    '{DIRECTED[i].exp_smp, DIRECTED[i].exp_clip});
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      // pick a coefficient set; the first two phases pin the extremes
      if (phase == 0) mix = MIX_TOP;
      else if (phase == 1) mix = MIX_BOTTOM;
      else mix = coef_mix_e'($urandom_range(int'(MIX_GENTLE), int'(MIX_EDGES)));
      for (int k = 0; k < NUM_COEFS; k++) begin
        if (mix == MIX_PASS)
          pending_writes.push_back('{COEF_REGS[k], (k == 0) ? B0_RESET : '0});
        else
          pending_writes.push_back('{COEF_REGS[k], rand_coef(mix)});
      end
      if ($urandom_range(0, 2) == 0)
        pending_writes.push_back('{CFG_IDX_W'($urandom_range(int'(IDX_VOID_LO),
                                   int'(IDX_VOID_HI))), CFG_DATA_W'($urandom())});
      flush_writes();

      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      n_items = $urandom_range(60, 160);
      repeat (n_items) begin
        send_sample(rand_sample(), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    no_idle = 1'b0;
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random backpressure, one long hold-off, and the checks
  initial begin
    int      rx_wait;
    result_t exp_res;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, actual sample %h clip %b",
                   $time, m_axis_tdata[SAMPLE_W-1:0], m_axis_tuser[0]);
          mismatch_cnt++;
        end else begin
          exp_res = filtered_q.pop_front();
          if (m_axis_tdata[SAMPLE_W-1:0] !== exp_res.smp) begin
            $display("%0t: sample mismatch, expected %h actual %h",
                     $time, exp_res.smp, m_axis_tdata[SAMPLE_W-1:0]);
            mismatch_cnt++;
          end
          if (m_axis_tuser[0] !== exp_res.clip) begin
            $display("%0t: clip mismatch, expected %b actual %b",
                     $time, exp_res.clip, m_axis_tuser[0]);
            mismatch_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        rx_wait  = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait = idle_len() - 1;
      end
    end
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* biquad_tdf2_filter.f */
rtl/bqf_pkg.sv
rtl/bqf_sequencer.sv
rtl/bqf_datapath.sv
rtl/biquad_tdf2_filter.sv
rtl/bqf_checker.sv
dv/biquad_tdf2_filter_test.sv
